>>> src/dq_pkg.sv
// double-ended queue package: operation and status codes, transfer structs
// no dependencies; imported by double_ended_queue
`default_nettype none

package dq_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [2:0] {
		OP_PUSH_REAR  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_REAR   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ_ALL   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		op_t                       operation;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  data;
		logic                      last;
	} rsp_t;

endpackage

`default_nettype wire

>>> src/dq_ram.sv
// generic single-clock ram: one write port, one read port, registered read data
// no dependencies; used by double_ended_queue for the word store
`default_nettype none

module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/double_ended_queue.sv
// double-ended queue top level: circular buffer over one ram, pointer control
// depends on dq_pkg and dq_ram
//
//   channel   signals                      direction   carries
//   req       req_valid, req_stall, req    in          operation, value
//   rsp       rsp_valid, rsp_stall, rsp    out         status, data, last
//   cfg       cfg_valid, cfg_ready, cfg_data in        capacity
//
// push and pop: an idle step updates the pointers and accesses the ram, then an emit
//   step loads the output register, from the ram's registered read data on a pop
// read-out: one ram read per stored word, one emit step per word
// reset leaves the queue empty with capacity 64; the word store needs no clearing
// rsp_stall holds the output register and the emit step; req is taken only when idle
`default_nettype none

module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output      logic             req_stall,
	input  wire req_t             req,
	output      logic             rsp_valid,
	input  wire logic             rsp_stall,
	output      rsp_t             rsp,
	input  wire logic             cfg_valid,
	output      logic             cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CAP_W-1:0]  cap_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     idx_q;
	status_t           pend_status_q;
	logic              pend_ram_q;
	logic              multi_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              accept;
	logic              out_free;
	logic              full;
	logic              empty;
	logic              dump_last;
	logic [CAP_W-1:0]  eff_cap;
	logic [AW-1:0]     slot_tail;
	logic [AW-1:0]     slot_last;
	logic [AW-1:0]     head_dec;
	logic [AW-1:0]     head_inc;
	logic [AW-1:0]     rd_ptr_inc;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
	                                           input logic [CW-1:0] offs);
		logic [AW:0] sum;
		sum = {1'b0, base} + (AW+1)'(offs);
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign eff_cap    = (cap_q > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_q;
	assign full       = (CAP_W'(count_q) >= eff_cap);
	assign empty      = (count_q == '0);
	assign dump_last  = ((idx_q + CW'(1)) == count_q);
	assign slot_tail  = wrap_add(head_q, count_q);
	assign slot_last  = wrap_add(head_q, count_q - CW'(1));
	assign head_dec   = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc   = wrap_inc(head_q);
	assign rd_ptr_inc = wrap_inc(rd_ptr_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_tail;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		if (accept) begin
			case (req.operation)
				OP_PUSH_REAR: begin
					ram_we = !full;
				end
				OP_PUSH_FRONT: begin
					ram_we    = !full;
					ram_waddr = head_dec;
				end
				OP_POP_REAR: begin
					ram_re    = !empty;
					ram_raddr = slot_last;
				end
				OP_POP_FRONT, OP_READ_ALL: begin
					ram_re = !empty;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end else if (state_q == S_EMIT && out_free && multi_q && !dump_last) begin
			ram_re    = 1'b1;
			ram_raddr = rd_ptr_inc;
		end
	end

	dq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req.value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			count_q       <= '0;
			cap_q         <= CAP_RESET;
			rd_ptr_q      <= '0;
			idx_q         <= '0;
			pend_status_q <= ST_OK;
			pend_ram_q    <= 1'b0;
			multi_q       <= 1'b0;
			rsp_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q       <= S_EMIT;
						pend_status_q <= ST_OK;
						pend_ram_q    <= 1'b0;
						multi_q       <= 1'b0;
						case (req.operation)
							OP_PUSH_REAR: begin
								if (full) begin
									pend_status_q <= ST_OVERFLOW;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_PUSH_FRONT: begin
								if (full) begin
									pend_status_q <= ST_OVERFLOW;
								end else begin
									head_q  <= head_dec;
									count_q <= count_q + CW'(1);
								end
							end
							OP_POP_REAR: begin
								if (empty) begin
									pend_status_q <= ST_UNDERFLOW;
								end else begin
									count_q    <= count_q - CW'(1);
									pend_ram_q <= 1'b1;
								end
							end
							OP_POP_FRONT: begin
								if (empty) begin
									pend_status_q <= ST_UNDERFLOW;
								end else begin
									head_q     <= head_inc;
									count_q    <= count_q - CW'(1);
									pend_ram_q <= 1'b1;
								end
							end
							OP_READ_ALL: begin
								if (empty) begin
									pend_status_q <= ST_UNDERFLOW;
								end else begin
									pend_ram_q <= 1'b1;
									multi_q    <= 1'b1;
									idx_q      <= '0;
									rd_ptr_q   <= head_q;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_EMIT: begin
					if (out_free) begin
						rsp_valid_q   <= 1'b1;
						rsp_q.status  <= pend_status_q;
						rsp_q.data    <= pend_ram_q ? ram_rdata : '0;
						rsp_q.last    <= !multi_q || dump_last;
						if (multi_q && !dump_last) begin
							idx_q    <= idx_q + CW'(1);
							rd_ptr_q <= rd_ptr_inc;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("word count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !full &&
		 (req.operation == OP_PUSH_REAR || req.operation == OP_PUSH_FRONT))
		|=> count_q == $past(count_q) + CW'(1))
		else $error("successful push did not grow the queue");

	a_dump_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && multi_q) |-> idx_q < count_q)
		else $error("read-out index left the live window");

	a_fail_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != ST_OK) |-> (rsp_q.data == '0 && rsp_q.last))
		else $error("failed operation result not zero and final");

endmodule

`default_nettype wire

>>> sim/dq_checker.sv
// double-ended queue checker: watches the req, rsp and cfg transfers, keeps its own
// copy of the queue and capacity, and compares every result field by field
// depends on dq_pkg
`timescale 1ns / 100ps

module dq_checker
	import dq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic             req_stall,
	input  wire req_t             req,
	input  wire logic             rsp_valid,
	input  wire logic             rsp_stall,
	input  wire rsp_t             rsp,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    outcomes_left,
	output int                    ops_seen,
	output int                    results_seen,
	output int                    overflow_seen,
	output int                    underflow_seen
);

	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [DATA_W-1:0] stored_words [DEPTH];
	logic [SLOT_W-1:0]        front_slot;
	logic [CAP_W-1:0]         word_fill;
	logic [CAP_W-1:0]         capacity_reg;
	rsp_t                     deque_outcomes [$];

	task automatic note_fault(input string what, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		if (fail_count < 100)
			$display("%0t ns: dq_checker: %s got %0h want %0h", $time, what, got, want);
		fail_count++;
	endtask

	function automatic int slot_of(input int offset);
		return (int'(front_slot) + offset) % DEPTH;
	endfunction

	task automatic apply_deque_op(input req_t item);
		int   room;
		int   i;
		rsp_t res;
		room       = (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
		res.status = ST_OK;
		res.data   = '0;
		res.last   = 1'b1;
		case (item.operation)
			OP_PUSH_REAR, OP_PUSH_FRONT: begin
				if (int'(word_fill) >= room) begin
					res.status = ST_OVERFLOW;
				end else if (item.operation == OP_PUSH_REAR) begin
					stored_words[slot_of(int'(word_fill))] = item.value;
					word_fill = word_fill + 1'b1;
				end else begin
					front_slot = SLOT_W'((int'(front_slot) + DEPTH - 1) % DEPTH);
					stored_words[front_slot] = item.value;
					word_fill = word_fill + 1'b1;
				end
				deque_outcomes.push_back(res);
			end
			OP_POP_REAR, OP_POP_FRONT: begin
				if (word_fill == 0) begin
					res.status = ST_UNDERFLOW;
				end else if (item.operation == OP_POP_REAR) begin
					res.data  = stored_words[slot_of(int'(word_fill) - 1)];
					word_fill = word_fill - 1'b1;
				end else begin
					res.data   = stored_words[front_slot];
					front_slot = SLOT_W'((int'(front_slot) + 1) % DEPTH);
					word_fill  = word_fill - 1'b1;
				end
				deque_outcomes.push_back(res);
			end
			OP_READ_ALL: begin
				if (word_fill == 0) begin
					res.status = ST_UNDERFLOW;
					deque_outcomes.push_back(res);
				end else begin
					for (i = 0; i < int'(word_fill) && i < DEPTH; i++) begin
						res.data = stored_words[slot_of(i)];
						res.last = (i + 1 == int'(word_fill));
						deque_outcomes.push_back(res);
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			deque_outcomes.delete();
			front_slot     = '0;
			word_fill      = '0;
			capacity_reg   = CAP_RESET;
			fail_count     = 0;
			outcomes_left  = 0;
			ops_seen       = 0;
			results_seen   = 0;
			overflow_seen  = 0;
			underflow_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				capacity_reg = cfg_data;
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (rsp.status == ST_OVERFLOW)
					overflow_seen++;
				if (rsp.status == ST_UNDERFLOW)
					underflow_seen++;
				if (deque_outcomes.size() == 0) begin
					note_fault("result with nothing outstanding, data", rsp.data, '0);
				end else begin
					want = deque_outcomes.pop_front();
					if (rsp.status != want.status)
						note_fault("status", 32'(rsp.status), 32'(want.status));
					if (rsp.data !== want.data)
						note_fault("data", rsp.data, want.data);
					if (rsp.last !== want.last)
						note_fault("last", 32'(rsp.last), 32'(want.last));
				end
			end
			if (req_valid && !req_stall) begin
				ops_seen++;
				apply_deque_op(req);
			end
			outcomes_left = deque_outcomes.size();
		end
	end

endmodule

>>> sim/double_ended_queue_test.sv
// double-ended queue testbench top: clock, reset, request and capacity stimulus
// with random gaps and result stalls; verdict from dq_checker
// depends on dq_pkg, double_ended_queue and dq_checker
`timescale 1ns / 100ps

module double_ended_queue_test;
	import dq_pkg::*;

	localparam int DEPTH     = 64;
	localparam int PHASES    = 10;
	localparam int PER_PHASE = 45;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	req_t             req       = '0;
	logic             rsp_stall = 1'b0;
	logic             cfg_valid = 1'b0;
	logic [CAP_W-1:0] cfg_data  = '0;
	logic             req_stall;
	logic             rsp_valid;
	rsp_t             rsp;
	logic             cfg_ready;

	int fail_count, outcomes_left, ops_seen, results_seen, overflow_seen, underflow_seen;
	int stall_left = 0;
	int free_left  = 0;
	bit quiet      = 1'b0;
	int cap_writes = 0;

	double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	dq_checker #(.DEPTH(DEPTH)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.outcomes_left  (outcomes_left),
		.ops_seen       (ops_seen),
		.results_seen   (results_seen),
		.overflow_seen  (overflow_seen),
		.underflow_seen (underflow_seen)
	);

	always #4 clk = ~clk;

	// result stalls: short free runs, mostly short stalls, now and then a long one
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else if (free_left > 0) begin
			rsp_stall <= 1'b0;
			free_left--;
		end else begin
			rsp_stall <= 1'b0;
			free_left  = $urandom_range(0, 12);
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(1, 3);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'hffff_ffff;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_op(input op_t op, input logic [DATA_W-1:0] word);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.operation <= op;
		req.value     <= word;
		req_valid     <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (outcomes_left != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		drain_results();
		cfg_data  <= cap;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	initial begin
		#50_000_000;
		$display("double_ended_queue_test: done, errors");
		$finish;
	end

	initial begin
		int phase_cap [PHASES];
		int push_pct [PHASES];
		int p;
		int n;
		int r;
		int waited;
		op_t op;

		phase_cap = '{64, 127, 5, 0, 1, 2, 64, 0, 100, 64};
		push_pct  = '{85, 85, 50, 20, 30, 50, 60, 50, 75, 30};
		phase_cap[7] = $urandom_range(1, 63);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// empty queue, front insertion on empty, extreme words, ignored codes
		send_op(OP_POP_REAR, pick_word());
		send_op(OP_POP_FRONT, pick_word());
		send_op(OP_READ_ALL, pick_word());
		send_op(OP_PUSH_FRONT, 32'h7fff_ffff);
		send_op(OP_PUSH_REAR, 32'h8000_0000);
		send_op(OP_PUSH_REAR, 32'hffff_ffff);
		send_op(OP_PUSH_FRONT, 32'h0000_0000);
		send_op(OP_READ_ALL, pick_word());
		send_op(OP_POP_FRONT, pick_word());
		send_op(OP_POP_REAR, pick_word());
		send_op(op_t'(3'd5), pick_word());
		send_op(op_t'(3'd6), pick_word());
		send_op(op_t'(3'd7), pick_word());
		send_op(OP_POP_REAR, pick_word());
		send_op(OP_POP_FRONT, pick_word());
		send_op(OP_POP_FRONT, pick_word());

		// capacity of one, then zero
		write_capacity(7'd1);
		send_op(OP_PUSH_REAR, pick_word());
		send_op(OP_PUSH_FRONT, pick_word());
		send_op(OP_PUSH_REAR, pick_word());
		send_op(OP_READ_ALL, pick_word());
		send_op(OP_POP_FRONT, pick_word());
		write_capacity(7'd0);
		send_op(OP_PUSH_REAR, pick_word());
		send_op(OP_PUSH_FRONT, pick_word());
		send_op(OP_POP_REAR, pick_word());
		send_op(OP_READ_ALL, pick_word());

		// random phases; queue contents carry over so capacity may drop below the fill
		for (p = 0; p < PHASES; p++) begin
			write_capacity(phase_cap[p][CAP_W-1:0]);
			quiet = (p == 2 || p == 6);
			n = 0;
			while (n < PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 2) begin
					send_op(op_t'($urandom_range(5, 7)), pick_word());
					continue;
				end
				if (r < 7)
					op = OP_READ_ALL;
				else if ($urandom_range(0, 99) < push_pct[p])
					op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
				else
					op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
				send_op(op, pick_word());
				n++;
			end
			quiet = 1'b0;
		end

		req_valid <= 1'b0;
		waited = 0;
		while (outcomes_left != 0 && waited < 200_000) begin
			@(negedge clk);
			waited++;
		end
		repeat (DEPTH + 8) @(negedge clk);
		if (outcomes_left != 0)
			$display("%0d expected results never arrived", outcomes_left);

		$display("summary: %0d operations, %0d results checked, %0d capacity writes",
			ops_seen, results_seen, cap_writes);
		$display("summary: %0d overflow and %0d underflow results", overflow_seen,
			underflow_seen);
		if (fail_count == 0 && outcomes_left == 0) begin
			$display("double_ended_queue_test: done, clean");
		end else begin
			$display("double_ended_queue_test: done, errors");
		end
		$finish;
	end

endmodule
